// ----- sv/dtts_pkg.sv -----
// Shared types, unit codes and unit factors for the duration text parser.
package dtts_pkg;

	// One byte of the duration string and its end-of-string mark.
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} byte_t;

	// One result: the total in seconds and the parse status.
	typedef struct packed {
		logic signed [31:0] seconds;
		logic               ok;
	} total_t;

	localparam int UnitW   = 3;
	localparam int FactorW = 25;

	typedef logic [UnitW-1:0] unit_t;

	localparam unit_t UNIT_NONE = 3'd0;
	localparam unit_t UNIT_S    = 3'd1;
	localparam unit_t UNIT_M    = 3'd2;
	localparam unit_t UNIT_H    = 3'd3;
	localparam unit_t UNIT_D    = 3'd4;
	localparam unit_t UNIT_W    = 3'd5;
	localparam unit_t UNIT_Y    = 3'd6;

	// A finished term, handed from the parser to the arithmetic stages.
	typedef struct packed {
		logic        term_end;
		logic [31:0] num;
		unit_t       unit;
		logic        last;
		logic        ok;
	} term_t;

	function automatic unit_t unit_of(input logic [7:0] c);
		unit_t u;
		unique case (c)
			8'h73, 8'h53: u = UNIT_S;
			8'h6D, 8'h4D: u = UNIT_M;
			8'h68, 8'h48: u = UNIT_H;
			8'h64, 8'h44: u = UNIT_D;
			8'h77, 8'h57: u = UNIT_W;
			8'h79, 8'h59: u = UNIT_Y;
			default:      u = UNIT_NONE;
		endcase
		return u;
	endfunction

	function automatic logic [FactorW-1:0] unit_factor(input unit_t u);
		logic [FactorW-1:0] f;
		unique case (u)
			UNIT_S:  f = 25'd1;
			UNIT_M:  f = 25'd60;
			UNIT_H:  f = 25'd3600;
			UNIT_D:  f = 25'd86400;
			UNIT_W:  f = 25'd604800;
			UNIT_Y:  f = 25'd31536000;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

// ----- sv/dtts_parse.sv -----
// Character-level parser: tracks the phase of the current term and its number.
module dtts_parse import dtts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  byte_t beat,
	output term_t term
);

	localparam logic [1:0] PH_BETWEEN = 2'd0;
	localparam logic [1:0] PH_SIGN    = 2'd1;
	localparam logic [1:0] PH_DIGITS  = 2'd2;
	localparam logic [1:0] PH_FAILED  = 2'd3;

	localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

	logic [1:0]  phase_q, phase_d;
	logic [30:0] val_q, val_d;
	logic        neg_q, neg_d;
	logic        seen_q, seen_d;

	logic        is_digit, is_blank, is_sign;
	logic [3:0]  digit;
	logic [34:0] val_x10;
	logic [30:0] val_acc;
	unit_t       unit_in;
	logic [30:0] term_val;
	logic        term_neg;

	assign is_digit = (beat.character >= 8'h30) && (beat.character <= 8'h39);
	assign is_blank = (beat.character == 8'h20) ||
	                  ((beat.character >= 8'h09) && (beat.character <= 8'h0D));
	assign is_sign  = (beat.character == 8'h2B) || (beat.character == 8'h2D);
	assign digit    = beat.character[3:0];
	assign unit_in  = unit_of(beat.character);

	// Times ten as two shifts, then the new digit, saturating at the largest magnitude.
	assign val_x10 = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1) + {31'b0, digit};
	assign val_acc = (|val_x10[34:31]) ? NumMax : val_x10[30:0];

	always_comb begin
		phase_d       = phase_q;
		val_d         = val_q;
		neg_d         = neg_q;
		seen_d        = seen_q;
		term_val      = val_q;
		term_neg      = neg_q;
		term.term_end = 1'b0;
		term.unit     = UNIT_S;
		term.ok       = 1'b0;
		term.last     = beat.last;

		unique case (phase_q)
			PH_BETWEEN: begin
				priority if (is_blank) begin
					phase_d = PH_BETWEEN;
				end else if (is_sign) begin
					neg_d   = (beat.character == 8'h2D);
					val_d   = '0;
					phase_d = PH_SIGN;
				end else if (is_digit) begin
					neg_d   = 1'b0;
					val_d   = {27'b0, digit};
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_FAILED;
				end
			end
			PH_SIGN: begin
				if (is_digit) begin
					val_d   = {27'b0, digit};
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_FAILED;
				end
			end
			PH_DIGITS: begin
				priority if (is_digit) begin
					val_d = val_acc;
				end else if (is_blank || (unit_in != UNIT_NONE)) begin
					term.term_end = 1'b1;
					term.unit     = is_blank ? UNIT_S : unit_in;
					seen_d        = 1'b1;
					val_d         = '0;
					neg_d         = 1'b0;
					phase_d       = PH_BETWEEN;
				end else begin
					phase_d = PH_FAILED;
				end
			end
			PH_FAILED: begin
				phase_d = PH_FAILED;
			end
			default: begin
				phase_d = PH_FAILED;
			end
		endcase

		// The end of the string closes an open number as a term in seconds.
		if (beat.last) begin
			priority if (phase_d == PH_DIGITS) begin
				term.term_end = 1'b1;
				term.unit     = UNIT_S;
				term_val      = val_d;
				term_neg      = neg_d;
				term.ok       = 1'b1;
			end else if (phase_d == PH_BETWEEN) begin
				term.ok = seen_d;
			end else begin
				term.ok = 1'b0;
			end
			phase_d = PH_BETWEEN;
			val_d   = '0;
			neg_d   = 1'b0;
			seen_d  = 1'b0;
		end

		term.num = term_neg ? (32'd0 - {1'b0, term_val}) : {1'b0, term_val};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BETWEEN;
			val_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			val_q   <= val_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
		end
	end

endmodule

// ----- sv/duration_text_to_seconds_core.sv -----
// Top level: parses a duration string one byte per beat and returns its total in seconds.
// Throughput: one byte per cycle, including the last of a string, while byte_stall is low.
// Path: the last byte of a string is parsed into stage 1, multiplied into stage 2 and
// accumulated into the output register, which then holds the result.
// Reset: arst_n clears the parse phase, the running total and all valid flags at once;
// the block can take a byte as soon as reset is released.
module duration_text_to_seconds_core import dtts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   byte_valid,
	output logic   byte_stall,
	input  byte_t  byte_data,
	output logic   total_valid,
	input  logic   total_stall,
	output total_t total_data
);

	// The pipeline is elastic: each stage holds a valid flag and moves on when the stage
	// after it is free. Only the beat that ends a string needs the output register, so
	// ordinary bytes keep flowing into the running total while a finished result waits
	// to be taken; the parser is held only when that waiting result blocks a second end
	// of string at the accumulate stage and the two stages before it are full.

	term_t term;
	logic  take;

	// Stage 1: the term finished by this byte, if any, and the end-of-string status.
	logic        v_s1;
	logic        term_end_s1;
	logic [31:0] num_s1;
	unit_t       unit_s1;
	logic        last_s1;
	logic        ok_s1;

	// Stage 2: the term's product with its unit factor, wrapped to 32 bits.
	logic        v_s2;
	logic [31:0] prod_s2;
	logic        last_s2;
	logic        ok_s2;

	logic [31:0] acc_q;
	logic [31:0] acc_sum;
	logic [56:0] prod_full;

	logic s2_move, s2_free, s1_free;

	// A string's final beat may only leave stage 2 once the output register can take it.
	assign s2_move    = v_s2 && !(last_s2 && total_valid && total_stall);
	assign s2_free    = !v_s2 || s2_move;
	assign s1_free    = !v_s1 || s2_free;
	assign byte_stall = !s1_free;
	assign take       = byte_valid && !byte_stall;

	dtts_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.beat   (byte_data),
		.term   (term)
	);

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			term_end_s1 <= term.term_end;
			num_s1      <= term.num;
			unit_s1     <= term.unit;
			last_s1     <= term.last;
			ok_s1       <= term.ok;
		end
	end

	// Two's complement wraps modulo 2^32, so the low 32 bits of the unsigned product are
	// the signed product the total needs.
	assign prod_full = {25'b0, num_s1} * {32'b0, unit_factor(unit_s1)};

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s2_free) begin
			prod_s2 <= term_end_s1 ? prod_full[31:0] : '0;
			last_s2 <= last_s1;
			ok_s2   <= ok_s1;
		end
	end

	// Accumulate stage: the running total, and the output register on a final beat.
	assign acc_sum = acc_q + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			total_valid <= 1'b0;
		end else begin
			if (s2_move) begin
				acc_q <= last_s2 ? '0 : acc_sum;
			end
			if (s2_move && last_s2) begin
				total_valid <= 1'b1;
			end else if (!total_stall) begin
				total_valid <= 1'b0;
			end
		end
	end

	// A failed parse reports zero seconds.
	always_ff @(posedge clk) begin
		if (s2_move && last_s2) begin
			total_data.seconds <= ok_s2 ? acc_sum : '0;
			total_data.ok      <= ok_s2;
		end
	end

`ifndef SYNTH
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_move && last_s2) |=> (acc_q == '0))
		else $error("running total not cleared after the end of a string");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(total_valid && !total_data.ok) |-> (total_data.seconds == '0))
		else $error("failed parse reports non-zero seconds");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (v_s1 && v_s2 && last_s2 && total_valid))
		else $error("input stalled while the pipeline has room");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(total_valid && total_stall) |=> (total_valid && $stable(total_data)))
		else $error("stalled result changed or was dropped");
`endif

endmodule
